>>> rtl/wte_pkg.sv
// Package for the wildcard-to-regex escaper: character codes, sizes and the item plan type.
`default_nettype none
package wte_pkg;

	// Widths and sizes
	localparam int UNIT_W      = 16;
	localparam int MAX_RESULTS = 7;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int BODY_MAX    = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHOLE_LINE        = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASTERISK_WILDCARD = 1'd1;

	// Character codes
	localparam logic [UNIT_W-1:0] CHR_NEWLINE   = 16'h000A;
	localparam logic [UNIT_W-1:0] CHR_SPACE     = 16'h0020;
	localparam logic [UNIT_W-1:0] CHR_DOLLAR    = 16'h0024;
	localparam logic [UNIT_W-1:0] CHR_LPAREN    = 16'h0028;
	localparam logic [UNIT_W-1:0] CHR_RPAREN    = 16'h0029;
	localparam logic [UNIT_W-1:0] CHR_ASTERISK  = 16'h002A;
	localparam logic [UNIT_W-1:0] CHR_DOT       = 16'h002E;
	localparam logic [UNIT_W-1:0] CHR_DIGIT_0   = 16'h0030;
	localparam logic [UNIT_W-1:0] CHR_DIGIT_9   = 16'h0039;
	localparam logic [UNIT_W-1:0] CHR_QUESTION  = 16'h003F;
	localparam logic [UNIT_W-1:0] CHR_UPPER_A   = 16'h0041;
	localparam logic [UNIT_W-1:0] CHR_UPPER_Z   = 16'h005A;
	localparam logic [UNIT_W-1:0] CHR_BACKSLASH = 16'h005C;
	localparam logic [UNIT_W-1:0] CHR_CARET     = 16'h005E;
	localparam logic [UNIT_W-1:0] CHR_LOWER_A   = 16'h0061;
	localparam logic [UNIT_W-1:0] CHR_LOWER_N   = 16'h006E;
	localparam logic [UNIT_W-1:0] CHR_LOWER_X   = 16'h0078;
	localparam logic [UNIT_W-1:0] CHR_LOWER_Z   = 16'h007A;
	localparam logic [UNIT_W-1:0] CTRL_LIMIT    = 16'h0020;
	localparam logic [UNIT_W-1:0] ASCII_LIMIT   = 16'h0080;

	// Everything one item expands to: result count and the units in order
	typedef struct packed {
		logic [CNT_W-1:0]                   count;
		logic [MAX_RESULTS-1:0][UNIT_W-1:0] units;
	} item_plan_t;

	// Lower-case hex digit for one nibble
	function automatic logic [UNIT_W-1:0] hex_digit(input logic [3:0] nib);
		logic [UNIT_W-1:0] ext;
		ext = {{(UNIT_W-4){1'b0}}, nib};
		if (nib < 4'd10) begin
			hex_digit = CHR_DIGIT_0 + ext;
		end else begin
			hex_digit = CHR_LOWER_A + ext - 16'd10;
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/wte_decode.sv
// Expands one held item into its list of regex text units and their count.
`default_nettype none
module wte_decode (
	input  wire logic                           whole_line,
	input  wire logic                           asterisk_wildcard,
	input  wire logic [wte_pkg::UNIT_W-1:0]     code_unit,
	input  wire logic                           has_char,
	input  wire logic                           first_unit,
	input  wire logic                           last_unit,
	output wte_pkg::item_plan_t                 plan
);

	logic                                            caret;
	logic                                            dollar;
	logic                                            passes;
	logic [wte_pkg::BODY_MAX-1:0][wte_pkg::UNIT_W-1:0] body;
	logic [wte_pkg::CNT_W-1:0]                       body_cnt;
	logic [wte_pkg::CNT_W-1:0]                       pos;

	// Units that go out unchanged
	assign passes = (code_unit >= wte_pkg::ASCII_LIMIT) || (code_unit == wte_pkg::CHR_SPACE)
		|| (code_unit >= wte_pkg::CHR_DIGIT_0 && code_unit <= wte_pkg::CHR_DIGIT_9)
		|| (code_unit >= wte_pkg::CHR_UPPER_A && code_unit <= wte_pkg::CHR_UPPER_Z)
		|| (code_unit >= wte_pkg::CHR_LOWER_A && code_unit <= wte_pkg::CHR_LOWER_Z);

	// Escape of the unit itself, without anchors
	always_comb begin
		body     = '0;
		body_cnt = '0;
		if (has_char) begin
			if (code_unit == wte_pkg::CHR_NEWLINE) begin
				body[0]  = wte_pkg::CHR_BACKSLASH;
				body[1]  = wte_pkg::CHR_LOWER_N;
				body_cnt = wte_pkg::CNT_W'(2);
			end else if (code_unit < wte_pkg::CTRL_LIMIT) begin
				body[0]  = wte_pkg::CHR_BACKSLASH;
				body[1]  = wte_pkg::CHR_LOWER_X;
				body[2]  = wte_pkg::hex_digit(code_unit[7:4]);
				body[3]  = wte_pkg::hex_digit(code_unit[3:0]);
				body_cnt = wte_pkg::CNT_W'(4);
			end else if (passes) begin
				body[0]  = code_unit;
				body_cnt = wte_pkg::CNT_W'(1);
			end else if (code_unit == wte_pkg::CHR_ASTERISK && asterisk_wildcard) begin
				body[0]  = wte_pkg::CHR_LPAREN;
				body[1]  = wte_pkg::CHR_DOT;
				body[2]  = wte_pkg::CHR_ASTERISK;
				body[3]  = wte_pkg::CHR_QUESTION;
				body[4]  = wte_pkg::CHR_RPAREN;
				body_cnt = wte_pkg::CNT_W'(5);
			end else begin
				body[0]  = wte_pkg::CHR_BACKSLASH;
				body[1]  = code_unit;
				body_cnt = wte_pkg::CNT_W'(2);
			end
		end
	end

	assign caret  = whole_line & first_unit;
	assign dollar = whole_line & last_unit;

	// Place caret, body and dollar into result slots
	always_comb begin
		plan.count = {{(wte_pkg::CNT_W-1){1'b0}}, caret} + body_cnt
			+ {{(wte_pkg::CNT_W-1){1'b0}}, dollar};
		pos = '0;
		for (int k = 0; k < wte_pkg::MAX_RESULTS; k++) begin
			pos = wte_pkg::CNT_W'(k) - {{(wte_pkg::CNT_W-1){1'b0}}, caret};
			plan.units[k] = '0;
			if (caret && k == 0) begin
				plan.units[k] = wte_pkg::CHR_CARET;
			end else if (pos < body_cnt) begin
				plan.units[k] = body[pos];
			end else if (dollar && pos == body_cnt) begin
				plan.units[k] = wte_pkg::CHR_DOLLAR;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/wildcard_to_regex_escaper_core.sv
// Top level of the wildcard-to-regex escaper: item register, result sequencer, output register.
// Each accepted item (one pattern code unit) is held in an input register and expanded into
// 0 to 7 regex text units, which leave one per cycle, out_ready permitting, through a
// registered output, run_end marking the last unit of each item. An item with no result gives
// no output; the next item is taken as the last unit is loaded, so plain text runs at one item
// per clock with out_ready high, a rate set by the single output register. Write whole_line
// (index 0) and asterisk_wildcard (index 1) only while the block is idle; only bit 0 is kept.
`default_nettype none
module wildcard_to_regex_escaper_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_we,
	input  wire logic [wte_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [wte_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input items
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [wte_pkg::UNIT_W-1:0]         code_unit,
	input  wire logic                               has_char,
	input  wire logic                               first_unit,
	input  wire logic                               last_unit,
	// result items
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [wte_pkg::UNIT_W-1:0]              out_unit,
	output logic                                    run_end
);

	logic                           whole_line_q;
	logic                           asterisk_wildcard_q;
	logic                           valid_s1;
	logic [wte_pkg::UNIT_W-1:0]     unit_s1;
	logic                           has_s1;
	logic                           first_s1;
	logic                           last_s1;
	logic [wte_pkg::CNT_W-1:0]      idx_q;
	logic                           out_valid_q;
	logic [wte_pkg::UNIT_W-1:0]     out_unit_q;
	logic                           run_end_q;
	wte_pkg::item_plan_t            plan;
	logic                           out_load;
	logic                           emit;
	logic                           emit_last;
	logic                           s1_done;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_line_q        <= 1'b0;
			asterisk_wildcard_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				wte_pkg::REG_WHOLE_LINE:        whole_line_q        <= cfg_data[0];
				wte_pkg::REG_ASTERISK_WILDCARD: asterisk_wildcard_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	wte_decode u_decode (
		.whole_line        (whole_line_q),
		.asterisk_wildcard (asterisk_wildcard_q),
		.code_unit         (unit_s1),
		.has_char          (has_s1),
		.first_unit        (first_s1),
		.last_unit         (last_s1),
		.plan              (plan)
	);

	// Sequencing: one unit per cycle into the output register while it can load
	assign out_load  = !out_valid_q || out_ready;
	assign emit      = valid_s1 && (plan.count != '0) && out_load;
	assign emit_last = emit && (idx_q == plan.count - wte_pkg::CNT_W'(1));
	assign s1_done   = valid_s1 && ((plan.count == '0) || emit_last);
	assign in_ready  = !valid_s1 || s1_done;

	// Held item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			unit_s1  <= code_unit;
			has_s1   <= has_char;
			first_s1 <= first_unit;
			last_s1  <= last_unit;
		end
	end

	// Result index within the held item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (emit_last) begin
			idx_q <= '0;
		end else if (emit) begin
			idx_q <= idx_q + wte_pkg::CNT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_unit_q <= plan.units[idx_q];
			run_end_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_unit  = out_unit_q;
	assign run_end   = run_end_q;

	// Checks
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (plan.count != '0) |-> idx_q < plan.count)
		else $error("result index beyond item result count");

	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> idx_q == '0)
		else $error("result index not cleared with no held item");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> idx_q == '0 && out_valid_q && run_end_q)
		else $error("last result did not close the item");

	a_no_accept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && valid_s1 |-> s1_done)
		else $error("new item taken while results still pending");

endmodule
`default_nettype wire

>>> verif/tb_wildcard_to_regex_escaper_core.sv
// Testbench for the wildcard-to-regex escaper core: directed and random patterns, checked per unit.
`timescale 1ns / 1ps
module tb_wildcard_to_regex_escaper_core;

	// One unit of expected regex text
	typedef struct packed {
		logic [wte_pkg::UNIT_W-1:0] unit;
		logic                       run_end;
	} regex_unit_t;

	localparam int SETTLE_CYCLES = 4;
	localparam string HEX_CHARS = "0123456789abcdef";

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [wte_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [wte_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [wte_pkg::UNIT_W-1:0]     code_unit = '0;
	logic                           has_char = 1'b0;
	logic                           first_unit = 1'b0;
	logic                           last_unit = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [wte_pkg::UNIT_W-1:0]     out_unit;
	logic                           run_end;

	// Shadow copy of the configuration
	logic whole_line_on = 1'b0;
	logic wildcard_on = 1'b0;

	regex_unit_t regex_text_q[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	wildcard_to_regex_escaper_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_unit  (code_unit),
		.has_char   (has_char),
		.first_unit (first_unit),
		.last_unit  (last_unit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_unit   (out_unit),
		.run_end    (run_end)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic is_plain(logic [wte_pkg::UNIT_W-1:0] u);
		return (u >= wte_pkg::ASCII_LIMIT) || (u == wte_pkg::CHR_SPACE) ||
			(u >= wte_pkg::CHR_DIGIT_0 && u <= wte_pkg::CHR_DIGIT_9) ||
			(u >= wte_pkg::CHR_UPPER_A && u <= wte_pkg::CHR_UPPER_Z) ||
			(u >= wte_pkg::CHR_LOWER_A && u <= wte_pkg::CHR_LOWER_Z);
	endfunction

	function automatic logic [wte_pkg::UNIT_W-1:0] nibble_char(logic [3:0] nib);
		return {8'h00, HEX_CHARS[nib]};
	endfunction

	// Expand one accepted item into the regex text it should produce
	task automatic expand_unit(logic [wte_pkg::UNIT_W-1:0] u, logic has, logic first,
		logic last);
		logic [wte_pkg::UNIT_W-1:0] text[wte_pkg::MAX_RESULTS];
		int n;
		regex_unit_t r;
		n = 0;
		if (whole_line_on && first) begin
			text[n] = wte_pkg::CHR_CARET; n++;
		end
		if (has) begin
			if (u == wte_pkg::CHR_NEWLINE) begin
				text[n] = wte_pkg::CHR_BACKSLASH; n++;
				text[n] = wte_pkg::CHR_LOWER_N; n++;
			end else if (u < wte_pkg::CTRL_LIMIT) begin
				text[n] = wte_pkg::CHR_BACKSLASH; n++;
				text[n] = wte_pkg::CHR_LOWER_X; n++;
				text[n] = nibble_char(u[7:4]); n++;
				text[n] = nibble_char(u[3:0]); n++;
			end else if (is_plain(u)) begin
				text[n] = u; n++;
			end else if (u == wte_pkg::CHR_ASTERISK && wildcard_on) begin
				text[n] = wte_pkg::CHR_LPAREN; n++;
				text[n] = wte_pkg::CHR_DOT; n++;
				text[n] = wte_pkg::CHR_ASTERISK; n++;
				text[n] = wte_pkg::CHR_QUESTION; n++;
				text[n] = wte_pkg::CHR_RPAREN; n++;
			end else begin
				text[n] = wte_pkg::CHR_BACKSLASH; n++;
				text[n] = u; n++;
			end
		end
		if (whole_line_on && last) begin
			text[n] = wte_pkg::CHR_DOLLAR; n++;
		end
		for (int i = 0; i < n; i++) begin
			r.unit = text[i];
			r.run_end = (i == n - 1);
			regex_text_q.push_back(r);
		end
	endtask

	task automatic note_mismatch(string what, logic [wte_pkg::UNIT_W-1:0] exp_v,
		logic [wte_pkg::UNIT_W-1:0] act_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %s: expected %h, got %h at %0t", what, exp_v, act_v, $realtime);
	endtask

	// Result side: random back-pressure and per-unit compare
	always @(posedge clk) begin
		regex_unit_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (regex_text_q.size() == 0) begin
				note_mismatch("unexpected unit", '0, out_unit);
			end else begin
				exp_r = regex_text_q.pop_front();
				if (out_unit !== exp_r.unit)
					note_mismatch("out_unit", exp_r.unit, out_unit);
				if (run_end !== exp_r.run_end)
					note_mismatch("run_end", wte_pkg::UNIT_W'(exp_r.run_end),
						wte_pkg::UNIT_W'(run_end));
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Present one item and hold it until accepted; valid stays up for a following item
	task automatic send_item(logic [wte_pkg::UNIT_W-1:0] u, logic has, logic first,
		logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		code_unit  <= u;
		has_char   <= has;
		first_unit <= first;
		last_unit  <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expand_unit(u, has, first, last);
	endtask

	// Hold off the sender until every expected unit has arrived
	task automatic wait_text_drained();
		in_valid <= 1'b0;
		while (regex_text_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [wte_pkg::CFG_IDX_W-1:0] idx,
		logic [wte_pkg::CFG_DATA_W-1:0] val);
		wait_text_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == wte_pkg::REG_WHOLE_LINE) whole_line_on = val[0];
		else if (idx == wte_pkg::REG_ASTERISK_WILDCARD) wildcard_on = val[0];
	endtask

	function automatic logic [wte_pkg::UNIT_W-1:0] pick_unit();
		logic [wte_pkg::UNIT_W-1:0] u;
		case ($urandom_range(9))
			0: u = wte_pkg::UNIT_W'($urandom_range(31));
			1: u = wte_pkg::CHR_NEWLINE;
			2: u = wte_pkg::CHR_ASTERISK;
			3: u = wte_pkg::UNIT_W'($urandom_range(16'h7F, 16'h21));
			4: u = wte_pkg::CHR_UPPER_A + wte_pkg::UNIT_W'($urandom_range(25));
			5: u = ($urandom_range(1) != 0)
				? wte_pkg::CHR_LOWER_A + wte_pkg::UNIT_W'($urandom_range(25))
				: wte_pkg::CHR_DIGIT_0 + wte_pkg::UNIT_W'($urandom_range(9));
			6: u = wte_pkg::CHR_SPACE;
			7: u = wte_pkg::UNIT_W'($urandom_range(16'hFFFF, 16'h80));
			default: u = wte_pkg::UNIT_W'($urandom);
		endcase
		return u;
	endfunction

	// One pattern; noisy ones get random flags and may drop the unit
	task automatic send_pattern(int len, logic noisy);
		logic has, first, last;
		for (int i = 0; i < len; i++) begin
			has = 1'b1;
			first = (i == 0);
			last = (i == len - 1);
			if (noisy) begin
				has = ($urandom_range(3) != 0);
				first = 1'($urandom_range(1));
				last = 1'($urandom_range(1));
			end
			send_item(pick_unit(), has, first, last);
		end
	endtask

	// Reset configuration: every escape class, no anchors, asterisk escaped
	task automatic test_default_escapes();
		send_item(wte_pkg::CHR_UPPER_A, 1'b1, 1'b1, 1'b0);
		send_item(wte_pkg::CHR_UPPER_Z, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_LOWER_A, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_LOWER_Z, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_DIGIT_0, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_DIGIT_9, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_SPACE, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_NEWLINE, 1'b1, 1'b0, 1'b0);
		send_item(16'h0000, 1'b1, 1'b0, 1'b0);
		send_item(16'h001F, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_ASTERISK, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::CHR_BACKSLASH, 1'b1, 1'b0, 1'b0);
		send_item(16'h007F, 1'b1, 1'b0, 1'b0);
		send_item(wte_pkg::ASCII_LIMIT, 1'b1, 1'b0, 1'b0);
		send_item(16'hFFFF, 1'b1, 1'b0, 1'b1);
		// empty pattern without anchors gives nothing
		send_item(16'hFFFF, 1'b0, 1'b1, 1'b1);
	endtask

	// Anchors, lazy group, empty pattern and odd flag placement
	task automatic test_anchors_and_wildcard();
		write_reg(wte_pkg::REG_WHOLE_LINE, 1'b1);
		write_reg(wte_pkg::REG_ASTERISK_WILDCARD, 1'b1);
		send_item(16'h0000, 1'b0, 1'b1, 1'b1);
		send_item(wte_pkg::CHR_ASTERISK, 1'b1, 1'b1, 1'b1);
		send_item(wte_pkg::CHR_LOWER_A, 1'b1, 1'b1, 1'b0);
		wait_text_drained();
		send_item(wte_pkg::CHR_NEWLINE, 1'b1, 1'b0, 1'b1);
		send_item(16'h0019, 1'b1, 1'b1, 1'b1);
		send_item(wte_pkg::CHR_ASTERISK, 1'b1, 1'b0, 1'b0);
		send_item(16'h5555, 1'b0, 1'b1, 1'b0);
		send_item(16'hAAAA, 1'b0, 1'b0, 1'b1);
		send_item(wte_pkg::CHR_CARET, 1'b1, 1'b1, 1'b1);
	endtask

	// Random patterns under every configuration with the given idling
	task automatic test_random_patterns(int snd_pct, int rcv_pct, int budget);
		int sent;
		int len;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int c = 0; c < 4; c++) begin
			write_reg(wte_pkg::REG_WHOLE_LINE, c[0]);
			write_reg(wte_pkg::REG_ASTERISK_WILDCARD, c[1]);
			sent = 0;
			while (sent < budget / 4) begin
				len = $urandom_range(8, 1);
				send_pattern(len, $urandom_range(99) < 15);
				sent += len;
				if ($urandom_range(19) == 0) wait_text_drained();
			end
		end
	endtask

	initial begin
		int guard;
		send_idle_pct = 11;
		recv_idle_pct = 58;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_default_escapes();
		test_anchors_and_wildcard();
		test_random_patterns(11, 58, 144);
		test_random_patterns(58, 11, 144);
		test_random_patterns(0, 0, 144);

		// drain and look for stragglers
		in_valid <= 1'b0;
		guard = 0;
		while (regex_text_q.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		if (regex_text_q.size() != 0) begin
			mismatch_count++;
			$display("%0d expected units never arrived", regex_text_q.size());
		end
		repeat (10) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> wildcard_to_regex_escaper_core.f
rtl/wte_pkg.sv
rtl/wte_decode.sv
rtl/wildcard_to_regex_escaper_core.sv
verif/tb_wildcard_to_regex_escaper_core.sv
